[rtl/rrs_pkg.sv]
// Shared widths, opcode codes and status codes for the round-robin sleep scheduler.
// No dependencies; every other file of the block imports this package.
package rrs_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int OP_W          = 2;
    localparam int CTX_W         = 64;
    localparam int ID_W          = 32;
    localparam int SLEEP_W       = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SPAWN = 2'd0,
        OP_TICK  = 2'd1,
        OP_YIELD = 2'd2
    } t_op;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

endpackage

[rtl/rrs_req_if.sv]
// Request channel of the scheduler: opcode, context word and sleep count.
// Depends on rrs_pkg for the field widths.
interface rrs_req_if;
    import rrs_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [CTX_W-1:0]   context_word;
    logic [SLEEP_W-1:0] sleep_count;

    modport source (output valid, output opcode, output context_word, output sleep_count,
                    input ready);
    modport sink   (input valid, input opcode, input context_word, input sleep_count,
                    output ready);
endinterface

[rtl/rrs_rsp_if.sv]
// Result channel of the scheduler: selected context, task id and status.
// Depends on rrs_pkg for the field widths.
interface rrs_rsp_if;
    import rrs_pkg::*;

    logic             valid;
    logic             ready;
    logic [CTX_W-1:0] selected_context;
    logic [ID_W-1:0]  task_id;
    logic             status;

    modport source (output valid, output selected_context, output task_id, output status,
                    input ready);
    modport sink   (input valid, input selected_context, input task_id, input status,
                    output ready);
endinterface

[rtl/rrs_sleep_alu.sv]
// Saturating sleep-count decrementer shared by every step of the ring walk.
// Depends on rrs_pkg for the sleep count width.
module rrs_sleep_alu (
    input  logic [rrs_pkg::SLEEP_W-1:0] i_value,
    input  logic                        i_twice,
    output logic [rrs_pkg::SLEEP_W-1:0] o_value,
    output logic                        o_zero
);
    import rrs_pkg::*;

    logic [SLEEP_W-1:0] dec;

    // The running task is decremented twice per tick, never below zero.
    assign dec     = i_twice ? SLEEP_W'(2) : SLEEP_W'(1);
    assign o_value = (i_value <= dec) ? '0 : (i_value - dec);
    assign o_zero  = (o_value == '0);

endmodule

[rtl/round_robin_sleep_scheduler_top.sv]
// Round-robin task scheduler with sleep counts; one request at a time.
// Path to result valid: yield via S_YIELD; refused spawn or unknown opcode to S_DONE;
// spawn scans to the lowest free slot, S_LINK1, S_LINK2; tick walks the N ring tasks,
// one slot per cycle through the shared decrementer and the single table read port.
// A new request is taken in the cycle after the result is registered.
// Synchronous active-low reset: the ring holds only task 0 in slot 0; no clearing pass.
module round_robin_sleep_scheduler_top #(
    parameter int MAX_TASKS = rrs_pkg::MAX_TASKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrs_req_if.sink    i_req,
    rrs_rsp_if.source  o_rsp
);
    import rrs_pkg::*;

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_YIELD  = 11'b000_0000_0010,
        S_SCAN   = 11'b000_0000_0100,
        S_LINK1  = 11'b000_0000_1000,
        S_LINK2  = 11'b000_0001_0000,
        S_TSTART = 11'b000_0010_0000,
        S_TFIRST = 11'b000_0100_0000,
        S_WALK   = 11'b000_1000_0000,
        S_TREAD  = 11'b001_0000_0000,
        S_TDATA  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    logic [SLOT_W-1:0]  mem_succ  [MAX_TASKS];
    logic [CTX_W-1:0]   mem_ctx   [MAX_TASKS];
    logic [SLEEP_W-1:0] mem_sleep [MAX_TASKS];
    logic [ID_W-1:0]    mem_id    [MAX_TASKS];

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_cur, n_cur;
    logic [ID_W-1:0]    r_cur_id, n_cur_id;
    logic [ID_W-1:0]    r_id_ctr, n_id_ctr;
    logic [MAX_TASKS-1:0] r_in_use, n_in_use;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_succ0_wr, n_succ0_wr;
    logic               r_sleep0_wr, n_sleep0_wr;
    logic [SLOT_W-1:0]  r_scan, n_scan;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [SLOT_W-1:0]  r_first, n_first;
    logic [SLOT_W-1:0]  r_it, n_it;
    logic [SLOT_W-1:0]  r_sel, n_sel;
    logic               r_found, n_found;
    logic [CTX_W-1:0]   r_ctx_in, n_ctx_in;
    logic [SLEEP_W-1:0] r_sleep_in, n_sleep_in;
    logic [CTX_W-1:0]   r_res_ctx, n_res_ctx;
    logic [ID_W-1:0]    r_res_id, n_res_id;
    logic               r_res_st, n_res_st;
    logic               r_out_valid, n_out_valid;
    logic [CTX_W-1:0]   r_out_ctx, n_out_ctx;
    logic [ID_W-1:0]    r_out_id, n_out_id;
    logic               r_out_st, n_out_st;

    logic [SLOT_W-1:0]  rd_addr, r_rd_addr;
    logic [SLOT_W-1:0]  r_rd_succ;
    logic [CTX_W-1:0]   r_rd_ctx;
    logic [SLEEP_W-1:0] r_rd_sleep;
    logic [ID_W-1:0]    r_rd_id;

    logic               succ_we, ctx_we, sleep_we, id_we;
    logic [SLOT_W-1:0]  succ_wa, ctx_wa, sleep_wa, id_wa;
    logic [SLOT_W-1:0]  succ_wd;
    logic [CTX_W-1:0]   ctx_wd;
    logic [SLEEP_W-1:0] sleep_wd;
    logic [ID_W-1:0]    id_wd;

    logic [SLOT_W-1:0]  succ_eff;
    logic [SLEEP_W-1:0] sleep_eff;
    logic [SLEEP_W-1:0] alu_value;
    logic               alu_zero;
    logic               req_acc;

    // Slot 0 is the only entry that can be read before it is written.
    assign succ_eff  = (r_rd_addr == '0 && !r_succ0_wr) ? '0 : r_rd_succ;
    assign sleep_eff = (r_rd_addr == '0 && !r_sleep0_wr) ? '0 : r_rd_sleep;

    rrs_sleep_alu u_alu (
        .i_value (sleep_eff),
        .i_twice (r_it == r_cur),
        .o_value (alu_value),
        .o_zero  (alu_zero)
    );

    assign i_req.ready            = (r_state == S_IDLE);
    assign req_acc                = i_req.valid && i_req.ready;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.selected_context = r_out_ctx;
    assign o_rsp.task_id          = r_out_id;
    assign o_rsp.status           = r_out_st;

    always_ff @(posedge i_clk) begin
        if (succ_we) begin
            mem_succ[succ_wa] <= succ_wd;
        end
        if (ctx_we) begin
            mem_ctx[ctx_wa] <= ctx_wd;
        end
        if (sleep_we) begin
            mem_sleep[sleep_wa] <= sleep_wd;
        end
        if (id_we) begin
            mem_id[id_wa] <= id_wd;
        end
        r_rd_succ  <= mem_succ[rd_addr];
        r_rd_ctx   <= mem_ctx[rd_addr];
        r_rd_sleep <= mem_sleep[rd_addr];
        r_rd_id    <= mem_id[rd_addr];
        r_rd_addr  <= rd_addr;
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_cur_id    = r_cur_id;
        n_id_ctr    = r_id_ctr;
        n_in_use    = r_in_use;
        n_count     = r_count;
        n_succ0_wr  = r_succ0_wr;
        n_sleep0_wr = r_sleep0_wr;
        n_scan      = r_scan;
        n_slot      = r_slot;
        n_first     = r_first;
        n_it        = r_it;
        n_sel       = r_sel;
        n_found     = r_found;
        n_ctx_in    = r_ctx_in;
        n_sleep_in  = r_sleep_in;
        n_res_ctx   = r_res_ctx;
        n_res_id    = r_res_id;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_ctx   = r_out_ctx;
        n_out_id    = r_out_id;
        n_out_st    = r_out_st;

        rd_addr  = r_cur;
        succ_we  = 1'b0;
        succ_wa  = r_cur;
        succ_wd  = r_slot;
        ctx_we   = 1'b0;
        ctx_wa   = r_cur;
        ctx_wd   = r_ctx_in;
        sleep_we = 1'b0;
        sleep_wa = r_cur;
        sleep_wd = r_sleep_in;
        id_we    = 1'b0;
        id_wa    = r_slot;
        id_wd    = r_id_ctr;

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_ctx_in   = i_req.context_word;
                    n_sleep_in = i_req.sleep_count;
                    n_res_ctx  = '0;
                    n_res_id   = '0;
                    n_res_st   = ST_OK;
                    case (i_req.opcode)
                        OP_SPAWN: begin
                            if (r_count == CNT_W'(MAX_TASKS)) begin
                                n_res_st = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_scan  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_TICK:  n_state = S_TSTART;
                        OP_YIELD: n_state = S_YIELD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_YIELD: begin
                sleep_we = 1'b1;
                if (r_cur == '0) begin
                    n_sleep0_wr = 1'b1;
                end
                n_res_id = r_cur_id;
                n_state  = S_DONE;
            end
            S_SCAN: begin
                if (!r_in_use[r_scan]) begin
                    n_slot  = r_scan;
                    n_state = S_LINK1;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_LINK1: begin
                succ_we  = 1'b1;
                succ_wa  = r_slot;
                succ_wd  = succ_eff;
                ctx_we   = 1'b1;
                ctx_wa   = r_slot;
                sleep_we = 1'b1;
                sleep_wa = r_slot;
                sleep_wd = '0;
                id_we    = 1'b1;
                n_in_use[r_slot] = 1'b1;
                n_count  = r_count + 1'b1;
                n_res_id = r_id_ctr;
                n_id_ctr = r_id_ctr + 1'b1;
                n_state  = S_LINK2;
            end
            S_LINK2: begin
                succ_we = 1'b1;
                if (r_cur == '0) begin
                    n_succ0_wr = 1'b1;
                end
                n_state = S_DONE;
            end
            S_TSTART: begin
                ctx_we  = 1'b1;
                n_state = S_TFIRST;
            end
            S_TFIRST: begin
                n_first = succ_eff;
                n_it    = succ_eff;
                n_found = 1'b0;
                rd_addr = succ_eff;
                n_state = S_WALK;
            end
            S_WALK: begin
                // The walk ends at the current task, so the first slot that reaches
                // zero on the way is the next one to run.
                sleep_we = 1'b1;
                sleep_wa = r_it;
                sleep_wd = alu_value;
                if (r_it == '0) begin
                    n_sleep0_wr = 1'b1;
                end
                if (!r_found && (alu_zero || r_it == r_cur)) begin
                    n_found = 1'b1;
                    n_sel   = r_it;
                end
                rd_addr = succ_eff;
                if (succ_eff == r_first) begin
                    n_state = S_TREAD;
                end else begin
                    n_it = succ_eff;
                end
            end
            S_TREAD: begin
                rd_addr = r_sel;
                n_state = S_TDATA;
            end
            S_TDATA: begin
                n_res_ctx = r_rd_ctx;
                n_res_id  = (r_sel == '0) ? '0 : r_rd_id;
                n_cur_id  = (r_sel == '0) ? '0 : r_rd_id;
                n_cur     = r_sel;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ctx   = r_res_ctx;
                    n_out_id    = r_res_id;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_cur_id    <= '0;
            r_id_ctr    <= ID_W'(1);
            r_in_use    <= MAX_TASKS'(1);
            r_count     <= CNT_W'(1);
            r_succ0_wr  <= 1'b0;
            r_sleep0_wr <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_cur_id    <= n_cur_id;
            r_id_ctr    <= n_id_ctr;
            r_in_use    <= n_in_use;
            r_count     <= n_count;
            r_succ0_wr  <= n_succ0_wr;
            r_sleep0_wr <= n_sleep0_wr;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_slot     <= n_slot;
        r_first    <= n_first;
        r_it       <= n_it;
        r_sel      <= n_sel;
        r_ctx_in   <= n_ctx_in;
        r_sleep_in <= n_sleep_in;
        r_res_ctx  <= n_res_ctx;
        r_res_id   <= n_res_id;
        r_res_st   <= n_res_st;
        r_out_ctx  <= n_out_ctx;
        r_out_id   <= n_out_id;
        r_out_st   <= n_out_st;
    end

`ifndef NO_ASSERTIONS
    a_slot0_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use[0])
        else $error("Slot 0 dropped out of the task table.");

    a_cur_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use[r_cur])
        else $error("The running slot holds no task.");

    a_walk_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (alu_value <= sleep_eff))
        else $error("A tick raised a sleep count.");

    a_tick_selects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TDATA) |-> r_found)
        else $error("A tick finished its ring walk without a selected task.");
`endif

endmodule
